// ----- hw/rtl/wstd_pkg.sv -----
// Shared types and constants for the work-stealing task deque.
package wstd_pkg;

  localparam int DEPTH_DEF     = 256;
  localparam int TASK_BITS_DEF = 16;
  localparam int TASK_W        = 16;
  localparam int OCC_W         = 9;

  typedef enum logic [1:0] {
    KIND_PUSH  = 2'd0,
    KIND_POP   = 2'd1,
    KIND_STEAL = 2'd2,
    KIND_NOP   = 2'd3
  } wstd_kind_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } wstd_status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [TASK_W-1:0] task_req;
  } wstd_req_t;

  typedef struct packed {
    logic [TASK_W-1:0] task_out;
    logic              task_valid;
    logic [1:0]        status;
    logic              is_empty;
    logic [OCC_W-1:0]  occupancy;
  } wstd_rsp_t;

  // result info registered by the controller; task word comes from the store
  typedef struct packed {
    logic             valid;
    logic             task_valid;
    logic [1:0]       status;
    logic             is_empty;
    logic [OCC_W-1:0] occupancy;
  } wstd_meta_t;

endpackage

// ----- hw/rtl/wstd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
module wstd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/wstd_ctrl.sv -----
// Index registers and operation decode; drives store accesses and result info.
module wstd_ctrl import wstd_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TASK_BITS = TASK_BITS_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  wstd_req_t            req,
  output logic                 we,
  output logic [AW-1:0]        waddr,
  output logic [TASK_BITS-1:0] wdata,
  output logic                 re,
  output logic [AW-1:0]        raddr,
  output wstd_meta_t           meta
);

  localparam logic [CW-1:0] FULL_IDX = CW'(DEPTH);

  logic [CW-1:0] bottom, bottom_next;
  logic [CW-1:0] top, top_next;
  logic [CW-1:0] bot_dec;
  logic          tvalid_next;
  logic [1:0]    status_next;
  logic [CW-1:0] occ_next;
  logic [TASK_BITS+TASK_W-1:0] req_wide;

  assign bot_dec  = bottom - CW'(1);
  assign req_wide = {{TASK_BITS{1'b0}}, req.task_req};
  assign wdata    = req_wide[TASK_BITS-1:0];

  always_comb begin
    bottom_next = bottom;
    top_next    = top;
    we          = 1'b0;
    waddr       = bottom[AW-1:0];
    re          = 1'b0;
    raddr       = bot_dec[AW-1:0];
    tvalid_next = 1'b0;
    status_next = ST_DONE;
    case (wstd_kind_t'(req.kind))
      KIND_PUSH: begin
        if (bottom == FULL_IDX) begin
          status_next = ST_FULL;
        end else begin
          we          = accept;
          bottom_next = bottom + CW'(1);
        end
      end
      KIND_POP: begin
        if (bottom == '0) begin
          status_next = ST_EMPTY;
        end else if (bot_dec > top) begin
          re          = accept;
          bottom_next = bot_dec;
          tvalid_next = 1'b1;
        end else if (bot_dec == top) begin
          // last task leaves: rewind both indices
          re          = accept;
          bottom_next = '0;
          top_next    = '0;
          tvalid_next = 1'b1;
        end else begin
          bottom_next = '0;
          top_next    = '0;
          status_next = ST_EMPTY;
        end
      end
      KIND_STEAL: begin
        raddr = top[AW-1:0];
        if (bottom <= top) begin
          status_next = ST_EMPTY;
        end else begin
          re          = accept;
          top_next    = top + CW'(1);
          tvalid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
    occ_next = (bottom_next > top_next) ? (bottom_next - top_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom     <= '0;
      top        <= '0;
      meta.valid <= 1'b0;
    end else begin
      meta.valid <= accept;
      if (accept) begin
        bottom <= bottom_next;
        top    <= top_next;
      end
    end
    if (accept) begin
      meta.task_valid <= tvalid_next;
      meta.status     <= status_next;
      meta.is_empty   <= (bottom_next <= top_next);
      meta.occupancy  <= OCC_W'(occ_next);
    end
  end

  a_top_le_bottom: assert property (@(posedge clk) disable iff (rst) top <= bottom)
    else $error("top index passed bottom index");

  a_bottom_bound: assert property (@(posedge clk) disable iff (rst) bottom <= FULL_IDX)
    else $error("bottom index beyond store depth");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> meta.valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !accept |=> !meta.valid)
    else $error("result without accepted word");

  a_task_read: assert property (@(posedge clk) disable iff (rst)
    (meta.valid && meta.task_valid) |-> $past(re))
    else $error("task returned without a store read");

  a_no_rw_same: assert property (@(posedge clk) disable iff (rst) !(we && re))
    else $error("store read and write in one cycle");

endmodule

// ----- hw/rtl/work_stealing_task_deque_core.sv -----
// Top level of the bounded work-stealing task deque.
// Result strobe (done) is registered: it rises in the cycle after start is accepted.
// Throughput: one operation per cycle; busy stays low, as the single-entry read or
//   write of the task store and the index update are both registered together.
// Reset clears both indices and the result strobe; the store is not cleared.
// The receiver cannot stall: done is high for a single cycle per result, and rsp holds until the next accepted start.
module work_stealing_task_deque_core import wstd_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int TASK_BITS = TASK_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  wstd_req_t req,
  output logic      done,
  output wstd_rsp_t rsp
);

  localparam int AW = $clog2(DEPTH);

  logic                 accept;
  logic                 we;
  logic                 re;
  logic [AW-1:0]        waddr;
  logic [AW-1:0]        raddr;
  logic [TASK_BITS-1:0] wdata;
  logic [TASK_BITS-1:0] rdata;
  logic [TASK_BITS+TASK_W-1:0] rd_wide;
  wstd_meta_t           meta;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  wstd_ctrl #(
    .DEPTH     (DEPTH),
    .TASK_BITS (TASK_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr  (raddr),
    .meta   (meta)
  );

  wstd_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_wide = {{TASK_W{1'b0}}, rdata};

  always_comb begin
    done           = meta.valid;
    rsp.task_out   = meta.task_valid ? rd_wide[TASK_W-1:0] : '0;
    rsp.task_valid = meta.task_valid;
    rsp.status     = meta.status;
    rsp.is_empty   = meta.is_empty;
    rsp.occupancy  = meta.occupancy;
  end

endmodule
